[src/assert_macros.svh]
// Assertion macros shared by the tokenizer modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[src/ltok_pkg.sv]
// Shared types and constants of the letter word tokenizer.
// No dependencies.
package ltok_pkg;

    localparam int MAX_WORD_LEN = 32;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int POS_W        = 16;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_EMIT,
        OP_ERROR,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [1:0]       status;
        logic [LEN_W-1:0] cnt;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } t_cmd;

endpackage

[src/letter_word_tokenizer_unit.sv]
// Top level of the letter word tokenizer: front end, command queue, back end.
// Depends on ltok_pkg, ltok_front, ltok_queue and ltok_back.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | i_char_code, i_end_of_input
//   out     | output    | o_out_valid / i_out_ready  | o_kind, o_word_char, o_last_of_word,
//           |           |                            | o_status, o_line_number, o_column_number
//
// A byte is taken each cycle while the four-entry command queue has room.
// The back end writes each letter into the word store; on ';' it reads the word
// back through S_READ and S_SHOW and takes no new command until the last letter.
// Word-store reads go through a single registered read port.
// Reset is synchronous, active low; the word store is not cleared.
// A stalled output holds the queue; the front end stalls once the queue is full.
module letter_word_tokenizer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_end_of_input,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_word_char,
    output logic                       o_last_of_word,
    output logic [1:0]                 o_status,
    output logic [ltok_pkg::POS_W-1:0] o_line_number,
    output logic [ltok_pkg::POS_W-1:0] o_column_number
);
    import ltok_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    ltok_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (push_cmd)
    );

    ltok_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    ltok_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_word_char     (o_word_char),
        .o_last_of_word  (o_last_of_word),
        .o_status        (o_status),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number)
    );

endmodule

[src/ltok_front.sv]
// Front end: accepts bytes, tracks line, column and word length, and
// turns each byte into at most one command for the back end. Uses ltok_pkg.
module ltok_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_input,
    input  logic                 i_q_full,
    output logic                 o_push,
    output ltok_pkg::t_cmd       o_cmd
);
    import ltok_pkg::*;
    `include "assert_macros.svh"

    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_line, n_line;
    logic [POS_W-1:0] r_col, n_col;
    logic             r_alf, n_alf;
    logic             r_halt, n_halt;
    logic [1:0]       r_code, n_code;

    logic             accept;
    logic             go;
    logic             err;
    logic [1:0]       err_code;
    logic             is_letter;
    logic             is_space;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign is_letter = ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A)) ||
                       ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A));
    assign is_space  = (i_char_code == CH_SP) || (i_char_code == CH_TAB) ||
                       (i_char_code == CH_VT) || (i_char_code == CH_FF);

    always_comb begin
        n_len    = r_len;
        n_line   = r_line;
        n_col    = r_col;
        n_alf    = r_alf;
        n_halt   = r_halt;
        n_code   = r_code;
        go       = 1'b0;
        err      = 1'b0;
        err_code = ST_OK;
        o_push   = 1'b0;
        o_cmd    = '{op: OP_WRITE, ch: '0, status: ST_OK, cnt: '0,
                     line: r_line, col: r_col};
        if (accept) begin
            if (i_end_of_input) begin
                o_push       = 1'b1;
                o_cmd.op     = OP_DONE;
                o_cmd.status = r_code;
                n_len        = '0;
                n_line       = POS_W'(1);
                n_col        = '0;
                n_alf        = 1'b0;
                n_halt       = 1'b0;
                n_code       = ST_OK;
            end else if (!r_halt) begin
                go = 1'b1;
                if (r_alf) begin
                    n_alf = 1'b0;
                    if (r_len != '0) begin
                        err      = 1'b1;
                        err_code = ST_INVALID;
                        go       = 1'b0;
                    end else begin
                        if (n_line != POS_MAX) n_line = n_line + 1'b1;
                        n_col = '0;
                        if (i_char_code == CH_CR) go = 1'b0;
                    end
                end
                if (go) begin
                    if (n_col != POS_MAX) n_col = n_col + 1'b1;
                    if (i_char_code == CH_LF) begin
                        n_alf = 1'b1;
                    end else if (i_char_code == CH_CR) begin
                        if (r_len != '0) begin
                            err      = 1'b1;
                            err_code = ST_INVALID;
                        end else begin
                            if (n_line != POS_MAX) n_line = n_line + 1'b1;
                            n_col = '0;
                        end
                    end else if (i_char_code == CH_SEMI) begin
                        if (r_len == '0) begin
                            err      = 1'b1;
                            err_code = ST_INVALID;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.op  = OP_EMIT;
                            o_cmd.cnt = r_len;
                            n_len     = '0;
                        end
                    end else if (is_letter) begin
                        if (r_len >= LEN_W'(MAX_WORD_LEN)) begin
                            err      = 1'b1;
                            err_code = ST_OVERFLOW;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.op  = OP_WRITE;
                            o_cmd.ch  = i_char_code;
                            o_cmd.cnt = r_len;
                            n_len     = r_len + 1'b1;
                        end
                    end else if (is_space) begin
                        if (r_len != '0) begin
                            err      = 1'b1;
                            err_code = ST_MISSING;
                        end
                    end
                end
                if (err) begin
                    o_push       = 1'b1;
                    o_cmd.op     = OP_ERROR;
                    o_cmd.status = err_code;
                    n_code       = err_code;
                    n_halt       = 1'b1;
                    n_len        = '0;
                end
                o_cmd.line = n_line;
                o_cmd.col  = n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_line <= POS_W'(1);
            r_col  <= '0;
            r_alf  <= 1'b0;
            r_halt <= 1'b0;
            r_code <= ST_OK;
        end else begin
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_alf  <= n_alf;
            r_halt <= n_halt;
            r_code <= n_code;
        end
    end

    `ASSERT_CLK(a_len_in_range, r_len <= LEN_W'(MAX_WORD_LEN), "word length past maximum")
    `ASSERT_CLK(a_line_nonzero, r_line != '0, "line count reached zero")

endmodule

[src/ltok_queue.sv]
// Short command queue between front and back end.
// Uses ltok_pkg for the command type.
module ltok_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ltok_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ltok_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import ltok_pkg::*;
    `include "assert_macros.svh"

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_q_push_full, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_q_pop_empty, i_pop && !o_valid, "pop from empty queue")

endmodule

[src/ltok_back.sv]
// Back end: runs queued commands, keeps the word store and drives the
// output register. Uses ltok_pkg.
module ltok_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  ltok_pkg::t_cmd          i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_word_char,
    output logic                    o_last_of_word,
    output logic [1:0]              o_status,
    output logic [ltok_pkg::POS_W-1:0] o_line_number,
    output logic [ltok_pkg::POS_W-1:0] o_column_number
);
    import ltok_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_line, n_line;
    logic [POS_W-1:0] r_col, n_col;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;
    logic [1:0]       r_status, n_status;
    logic [POS_W-1:0] r_oline, n_oline;
    logic [POS_W-1:0] r_ocol, n_ocol;

    logic [7:0]       r_mem [MAX_WORD_LEN];
    logic [7:0]       r_rd_data;
    logic             we;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free;
    logic             at_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign at_last  = ((LEN_W'(r_idx) + LEN_W'(1)) == r_len);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_line      = r_line;
        n_col       = r_col;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        n_status    = r_status;
        n_oline     = r_oline;
        n_ocol      = r_ocol;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_WRITE: begin
                            we      = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        OP_EMIT: begin
                            o_q_pop = 1'b1;
                            n_len   = i_q_cmd.cnt;
                            n_line  = i_q_cmd.line;
                            n_col   = i_q_cmd.col;
                            n_idx   = '0;
                            n_state = S_READ;
                        end
                        default: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_kind      = (i_q_cmd.op == OP_ERROR) ? KIND_ERROR
                                                                       : KIND_DONE;
                                n_char      = '0;
                                n_last      = 1'b0;
                                n_status    = i_q_cmd.status;
                                n_oline     = i_q_cmd.line;
                                n_ocol      = i_q_cmd.col;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CHAR;
                    n_char      = r_rd_data;
                    n_last      = at_last;
                    n_status    = ST_OK;
                    n_oline     = r_line;
                    n_ocol      = r_col;
                    if (at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[i_q_cmd.cnt[IDX_W-1:0]] <= i_q_cmd.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_len       <= n_len;
        end
        r_line   <= n_line;
        r_col    <= n_col;
        r_kind   <= n_kind;
        r_char   <= n_char;
        r_last   <= n_last;
        r_status <= n_status;
        r_oline  <= n_oline;
        r_ocol   <= n_ocol;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_word_char     = r_char;
    assign o_last_of_word  = r_last;
    assign o_status        = r_status;
    assign o_line_number   = r_oline;
    assign o_column_number = r_ocol;

    `ASSERT_CLK(a_idx_below_len, (r_state != S_IDLE) |-> (LEN_W'(r_idx) < r_len),
                "emit index past word length")

endmodule

[tb/tb_checker.sv]
// Checker for the letter word tokenizer: tracks line, column and the pending word,
// predicts every result and compares each accepted result with the oldest prediction.
// Depends on ltok_pkg.
`timescale 1ns / 1ps
module tb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_end_of_input,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [1:0]                 i_kind,
    input  logic [7:0]                 i_word_char,
    input  logic                       i_last_of_word,
    input  logic [1:0]                 i_status,
    input  logic [ltok_pkg::POS_W-1:0] i_line_number,
    input  logic [ltok_pkg::POS_W-1:0] i_column_number,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output int                         o_checked
);
    import ltok_pkg::*;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       ch;
        logic             last;
        logic [1:0]       status;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } t_token;

    t_token           expected_tokens[$];
    t_token           want;
    logic [7:0]       word_buf [MAX_WORD_LEN];
    int               word_len;
    logic [POS_W-1:0] line_cnt;
    logic [POS_W-1:0] col_cnt;
    logic             lf_pending;
    logic             halted;
    logic [1:0]       run_status;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (o_fail_count < 40)
            $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    function automatic void clear_state();
        word_len   = 0;
        line_cnt   = POS_W'(1);
        col_cnt    = '0;
        lf_pending = 1'b0;
        halted     = 1'b0;
        run_status = ST_OK;
    endfunction

    function automatic void push_token(input logic [1:0] kind, input logic [7:0] ch,
                                       input logic last, input logic [1:0] status);
        t_token tok;
        tok.kind   = kind;
        tok.ch     = ch;
        tok.last   = last;
        tok.status = status;
        tok.line   = line_cnt;
        tok.col    = col_cnt;
        expected_tokens.push_back(tok);
    endfunction

    function automatic void flag_error(input logic [1:0] status);
        push_token(KIND_ERROR, 8'h00, 1'b0, status);
        run_status = status;
        halted     = 1'b1;
        word_len   = 0;
    endfunction

    function automatic void advance_line();
        if (line_cnt != POS_MAX)
            line_cnt++;
        col_cnt = '0;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] ch, input logic eoi);
        if (eoi) begin
            push_token(KIND_DONE, 8'h00, 1'b0, run_status);
            clear_state();
            return;
        end
        if (halted)
            return;
        if (lf_pending) begin
            lf_pending = 1'b0;
            if (word_len > 0) begin
                flag_error(ST_INVALID);
                return;
            end
            advance_line();
            if (ch == CH_CR)
                return;
        end
        if (col_cnt != POS_MAX)
            col_cnt++;
        if (ch == CH_LF) begin
            lf_pending = 1'b1;
        end else if (ch == CH_CR) begin
            if (word_len > 0)
                flag_error(ST_INVALID);
            else
                advance_line();
        end else if (ch == CH_SEMI) begin
            if (word_len == 0) begin
                flag_error(ST_INVALID);
            end else begin
                for (int i = 0; i < word_len; i++)
                    push_token(KIND_CHAR, word_buf[i], i == word_len - 1, ST_OK);
                word_len = 0;
            end
        end else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
            if (word_len >= MAX_WORD_LEN) begin
                flag_error(ST_OVERFLOW);
            end else begin
                word_buf[word_len] = ch;
                word_len++;
            end
        end else if (ch == CH_SP || ch == CH_TAB || ch == CH_VT || ch == CH_FF) begin
            if (word_len > 0)
                flag_error(ST_MISSING);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_tokens.delete();
            clear_state();
        end else begin
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_char_code, i_end_of_input);
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected result, kind", 32'(i_kind), 32'(0));
                end else begin
                    want = expected_tokens.pop_front();
                    o_checked++;
                    if (i_kind !== want.kind)
                        report_mismatch("kind", 32'(i_kind), 32'(want.kind));
                    if (i_word_char !== want.ch)
                        report_mismatch("word_char", 32'(i_word_char), 32'(want.ch));
                    if (i_last_of_word !== want.last)
                        report_mismatch("last_of_word", 32'(i_last_of_word),
                                        32'(want.last));
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_line_number !== want.line)
                        report_mismatch("line_number", 32'(i_line_number),
                                        32'(want.line));
                    if (i_column_number !== want.col)
                        report_mismatch("column_number", 32'(i_column_number),
                                        32'(want.col));
                end
            end
        end
        o_outstanding = expected_tokens.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the tokenizer testbench: clock, reset, byte stimulus and the verdict.
// Depends on ltok_pkg, letter_word_tokenizer_unit and tb_checker.
`timescale 1ns / 1ps
module tb_top;
    import ltok_pkg::*;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic [7:0]       i_char_code    = 8'h00;
    logic             i_end_of_input = 1'b0;
    logic             i_out_ready    = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [1:0]       o_kind;
    logic [7:0]       o_word_char;
    logic             o_last_of_word;
    logic [1:0]       o_status;
    logic [POS_W-1:0] o_line_number;
    logic [POS_W-1:0] o_column_number;

    int fail_count;
    int outstanding;
    int checked_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    always #5 i_clk = ~i_clk;

    letter_word_tokenizer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_end_of_input  (i_end_of_input),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_word_char     (o_word_char),
        .o_last_of_word  (o_last_of_word),
        .o_status        (o_status),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number)
    );

    tb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_end_of_input  (i_end_of_input),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_kind          (o_kind),
        .i_word_char     (o_word_char),
        .i_last_of_word  (o_last_of_word),
        .i_status        (o_status),
        .i_line_number   (o_line_number),
        .i_column_number (o_column_number),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_checked       (checked_count)
    );

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] ch, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid  = 1'b0;
            i_char_code = 8'($urandom_range(255));
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_char_code    = ch;
        i_end_of_input = eoi;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic end_text();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_word(input int len);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(1) ? 8'h41 + 8'($urandom_range(25))
                                        : 8'h61 + 8'($urandom_range(25)), 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic drain();
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic random_segment();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 55) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_WORD_LEN - 2, MAX_WORD_LEN + 1)
                                           : $urandom_range(1, 6);
            send_word(len);
            send_byte(CH_SEMI, 1'b0);
            if (len > MAX_WORD_LEN)
                end_text();
        end else if (pick < 65) begin
            case ($urandom_range(2))
                0: send_byte(CH_LF, 1'b0);
                1: send_byte(CH_CR, 1'b0);
                default: begin
                    send_byte(CH_LF, 1'b0);
                    send_byte(CH_CR, 1'b0);
                end
            endcase
        end else if (pick < 75) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else if (pick < 82) begin
            send_byte(pick_space(), 1'b0);
        end else if (pick < 92) begin
            send_word($urandom_range(1, 4));
            case ($urandom_range(3))
                0: send_byte(pick_space(), 1'b0);
                1: send_byte(CH_CR, 1'b0);
                2: begin
                    send_byte(CH_LF, 1'b0);
                    send_word(1);
                end
                default: send_byte(CH_LF, 1'b0);
            endcase
            end_text();
        end else if (pick < 96) begin
            send_byte(CH_SEMI, 1'b0);
            end_text();
        end else begin
            end_text();
        end
    endtask

    initial begin
        int phase_start;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_string("AZaz;");
        send_byte(CH_SEMI, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_string("q");
        send_byte(CH_SP, 1'b0);
        end_text();
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_VT, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_string("k;m");
        send_byte(CH_CR, 1'b0);
        end_text();
        send_string("n");
        send_byte(CH_LF, 1'b0);
        end_text();
        send_string("p");
        send_byte(CH_LF, 1'b0);
        send_string("x");
        end_text();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 27 : 0;
            recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 27 : 0;
            phase_start    = items_sent;
            while (items_sent - phase_start < 22)
                random_segment();
            drain();
        end

        send_idle_pct = 0;
        send_string("end;");
        end_text();
        drain();
        repeat (100) @(negedge i_clk);

        $display("%0d input items sent, %0d results checked", items_sent, checked_count);
        $display("covered: errors, newline forms, word overflow, idle and stall phases");
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
